// ===== src/assert_macros.svh =====
// Assertion macros shared by the histogram RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define RFTH_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define RFTH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/rfth_pkg.sv =====
// Types, codes and constants of the RF-referenced time histogram.
package rfth_pkg;

    // Default geometry of the histogram store
    localparam int POSITIONS_DEFAULT = 16;
    localparam int CRYSTALS_DEFAULT  = 4;
    localparam int BINS_DEFAULT      = 32768;

    // Sub-bin resolution of the RF time: 16 steps per sample
    localparam int SUB_BITS = 4;
    localparam int SUB_STEPS = 1 << SUB_BITS;
    // Hits without RF land in bin BINS minus this offset
    localparam int NO_RF_OFFSET = 4;
    // Width of the referenced time in sub-bins, sign included
    localparam int W_WIDTH = 30;

    // Command codes
    localparam logic CMD_RECORD = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    typedef struct packed {
        logic        command;
        logic [3:0]  position;
        logic [1:0]  crystal;
        logic [23:0] hit_time;
        logic        time_valid;
        logic        rf_present;
        logic [27:0] rf_time_x16;
        logic [14:0] bin_index;
    } rfth_req_t;

    typedef struct packed {
        logic [31:0] bin_count;
        logic        accepted;
    } rfth_rsp_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CALC,
        ST_READ,
        ST_DONE
    } rfth_state_t;

endpackage

// ===== src/rfth_if.sv =====
// Valid/ready stream interface carrying one payload per transfer.
interface rfth_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== src/rf_referenced_time_histogram.sv =====
// Top level of the RF-referenced time histogram: store, sequencer and result register.
//
// Usage:
//   req carries one command per transfer (rfth_req_t): a record of one hit, or a
//   read of one stored bin count. rsp returns exactly one result (rfth_rsp_t) per
//   command, in order: bin_count for a read, accepted for a record.
//   Each command runs accept, address calculation, memory read and write-back in
//   turn on the count memory, so the block takes a new command only after the
//   last has finished write-back; the result is loaded into the output register
//   at write-back. The next request is taken as soon as the sequencer is idle,
//   even while an earlier result still waits in the output register.
//   After reset the block sweeps the store to zero, one entry per cycle, over all
//   POSITIONS*CRYSTALS*BINS entries (2,097,152 at the defaults); req.ready stays
//   low during the sweep.
//   When the receiver stalls, the finished item waits in the write-back step
//   without touching the memory until the output register frees up; req.ready
//   then stays low until the earlier result has been taken.
`include "assert_macros.svh"

module rf_referenced_time_histogram #(
    parameter int POSITIONS = rfth_pkg::POSITIONS_DEFAULT,
    parameter int CRYSTALS  = rfth_pkg::CRYSTALS_DEFAULT,
    parameter int BINS      = rfth_pkg::BINS_DEFAULT
) (
    input logic    clk,
    input logic    rst_n,
    rfth_if.sink   req,
    rfth_if.source rsp
);
    import rfth_pkg::*;

    localparam int SLOTS = POSITIONS * CRYSTALS;
    localparam int DEPTH = SLOTS * BINS;
    localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int QW    = $clog2(BINS);
    localparam int BW    = QW + 1;

    // Count store
    logic [31:0] mem [DEPTH];

    // Sequencer state
    rfth_state_t state_reg, state_next;
    logic [AW-1:0] clr_addr_reg;
    logic          out_valid_reg, out_valid_next;
    rfth_rsp_t     out_reg;

    // Per-item registers
    logic           cmd_reg;
    logic           slot_ok_reg;
    logic           tvalid_reg;
    logic           rf_reg;
    logic [SW-1:0]  slot_reg;
    logic [W_WIDTH-1:0] w_reg;
    logic [14:0]    bidx_reg;
    logic           inc_reg;
    logic           rd_ok_reg;
    logic [AW-1:0]  addr_reg;
    logic [31:0]    rd_data_reg;

    // Control strobes
    logic accept;
    logic finish;
    logic mem_we;
    logic [AW-1:0] mem_waddr;
    logic [31:0]   mem_wdata;

    // Referenced time and slot of an incoming request
    logic [W_WIDTH-1:0] w_in;
    logic               slot_ok_in;
    logic [SW-1:0]      slot_in;

    assign w_in = {2'b00, req.data.hit_time, {SUB_BITS{1'b0}}}
                + W_WIDTH'(SUB_STEPS * (BINS / 2))
                - {2'b00, req.data.rf_time_x16};
    assign slot_ok_in = (32'(req.data.position) < POSITIONS)
                     && (32'(req.data.crystal) < CRYSTALS);
    assign slot_in = SW'(32'(req.data.position) * CRYSTALS + 32'(req.data.crystal));

    // Bin of a recorded hit: range check, round half to even
    logic          w_in_range;
    logic          round_up;
    logic [BW-1:0] q_round;
    logic          rf_bin_ok;
    logic [QW-1:0] hit_bin;
    logic          record_ok;
    logic          read_ok;
    logic [QW-1:0] read_bin;
    logic [AW-1:0] addr_calc;

    always_comb
    begin
        w_in_range = !w_reg[W_WIDTH-1]
                  && (w_reg[W_WIDTH-2:0] < (W_WIDTH-1)'(SUB_STEPS * BINS));
        round_up   = (w_reg[SUB_BITS-1:0] > 4'd8)
                  || ((w_reg[SUB_BITS-1:0] == 4'd8) && w_reg[SUB_BITS]);
        q_round    = {1'b0, w_reg[SUB_BITS +: QW]} + BW'(round_up);
        rf_bin_ok  = w_in_range && (32'(q_round) < BINS);
        hit_bin    = rf_reg ? q_round[QW-1:0] : QW'(BINS - NO_RF_OFFSET);
        record_ok  = tvalid_reg && slot_ok_reg && (!rf_reg || rf_bin_ok);
        read_ok    = slot_ok_reg && (32'(bidx_reg) < BINS);
        read_bin   = QW'(bidx_reg);
        if (cmd_reg == CMD_READ)
        begin
            addr_calc = AW'(32'(slot_reg) * BINS + 32'(read_bin));
        end
        else
        begin
            addr_calc = AW'(32'(slot_reg) * BINS + 32'(hit_bin));
        end
    end

    // Next state, handshake and memory write control
    always_comb
    begin
        state_next     = state_reg;
        req.ready      = 1'b0;
        accept         = 1'b0;
        finish         = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = addr_reg;
        mem_wdata      = (rd_data_reg == 32'hFFFF_FFFF) ? rd_data_reg : rd_data_reg + 32'd1;
        out_valid_next = out_valid_reg && !rsp.ready;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                mem_wdata = '0;
                if (clr_addr_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    accept     = 1'b1;
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                state_next = ST_READ;
            end
            ST_READ:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    finish         = 1'b1;
                    mem_we         = inc_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
        end
    end

    // Item payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg     <= req.data.command;
            slot_ok_reg <= slot_ok_in;
            tvalid_reg  <= req.data.time_valid;
            rf_reg      <= req.data.rf_present;
            slot_reg    <= slot_in;
            w_reg       <= w_in;
            bidx_reg    <= req.data.bin_index;
        end
        if (state_reg == ST_CALC)
        begin
            addr_reg  <= addr_calc;
            inc_reg   <= (cmd_reg == CMD_RECORD) && record_ok;
            rd_ok_reg <= (cmd_reg == CMD_READ) && read_ok;
        end
        if (finish)
        begin
            out_reg.bin_count <= rd_ok_reg ? rd_data_reg : 32'd0;
            out_reg.accepted  <= inc_reg;
        end
    end

    // Count memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (state_reg == ST_READ)
        begin
            rd_data_reg <= mem[addr_reg];
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

    // Checks
    `RFTH_ASSERT_IMPL(a_no_req_in_clear, clk, rst_n, state_reg == ST_CLEAR, !req.ready, "request taken during clear")
    `RFTH_ASSERT_IMPL(a_read_no_write, clk, rst_n, (state_reg == ST_DONE) && (cmd_reg == CMD_READ), !mem_we, "read command wrote the store")
    `RFTH_ASSERT_NEXT(a_done_gives_result, clk, rst_n, finish, out_valid_reg, "finished item left no result")
    `RFTH_ASSERT_IMPL(a_accepted_no_count, clk, rst_n, rsp.valid && rsp.data.accepted, rsp.data.bin_count == 32'd0, "record result carries a count")

endmodule
